[rtl/core/efs_pkg.sv]
// efs_pkg: types, codes and the escape table of the escaped field splitter
// depends on nothing; imported by every module of the design and the bench

package efs_pkg;

   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [7:0] BACKSLASH     = 8'h5C;
   localparam logic [7:0] DELIM_DEFAULT = 8'd44;

   // result queue geometry
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic [1:0] out_kind;
      logic [7:0] out_byte;
      logic       record_end;
      logic       run_last;
   } res_type;

   typedef struct packed {
      logic       known;
      logic [7:0] value;
   } esc_type;

   // decoder outcome for one accepted beat
   typedef struct packed {
      logic [1:0] count;
      res_type    res0;
      res_type    res1;
      logic       escape_next;
      logic       skip_next;
   } dec_type;

   function automatic esc_type decode_escape(input logic [7:0] c);
      esc_type e;
      e.known = 1'b1;
      case (c)
         8'h27:   e.value = 8'h27;
         8'h22:   e.value = 8'h22;
         8'h3F:   e.value = 8'h3F;
         8'h5C:   e.value = 8'h5C;
         8'h61:   e.value = 8'h07;  // a
         8'h62:   e.value = 8'h08;  // b
         8'h66:   e.value = 8'h0C;  // f
         8'h6E:   e.value = 8'h0A;  // n
         8'h72:   e.value = 8'h0D;  // r
         8'h74:   e.value = 8'h09;  // t
         8'h76:   e.value = 8'h0B;  // v
         default: begin
            e.known = 1'b0;
            e.value = 8'h00;
         end
      endcase
      return e;
   endfunction

endpackage

[rtl/core/efs_req_if.sv]
// efs_req_if: request channel of the escaped field splitter, one record byte a beat
// no dependencies

interface efs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       byte_valid;
   logic       record_last;

   modport source (output valid, in_byte, byte_valid, record_last, input ready);
   modport sink   (input valid, in_byte, byte_valid, record_last, output ready);
endinterface

[rtl/core/efs_rsp_if.sv]
// efs_rsp_if: response channel of the escaped field splitter, one result a beat
// no dependencies

interface efs_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] out_kind;
   logic [7:0] out_byte;
   logic       record_end;
   logic       run_last;

   modport source (output valid, out_kind, out_byte, record_end, run_last, input ready);
   modport sink   (input valid, out_kind, out_byte, record_end, run_last, output ready);
endinterface

[rtl/core/efs_decode.sv]
// efs_decode: combinational escape and delimiter decode of one request beat
// depends on efs_pkg

module efs_decode
   import efs_pkg::*;
(
   input  logic [7:0] in_byte,
   input  logic       byte_valid,
   input  logic       record_last,
   input  logic [7:0] delim,
   input  logic       escape_pending,
   input  logic       skip_to_record_end,
   output dec_type    dec
);

   esc_type esc;
   logic    add_close;

   assign esc = decode_escape(in_byte);

   always_comb begin
      dec             = '0;
      dec.escape_next = escape_pending;
      dec.skip_next   = skip_to_record_end;
      add_close       = 1'b0;

      if (skip_to_record_end) begin
         if (record_last) begin
            dec.skip_next   = 1'b0;
            dec.escape_next = 1'b0;
         end
      end else if (!byte_valid) begin
         if (record_last) begin
            dec.count           = 2'd1;
            dec.res0.out_kind   = escape_pending ? KIND_ERROR : KIND_END;
            dec.res0.record_end = 1'b1;
            dec.escape_next     = 1'b0;
         end
      end else if (escape_pending) begin
         dec.escape_next = 1'b0;
         dec.count       = 2'd1;
         if (in_byte == delim) begin
            dec.res0.out_kind = KIND_DATA;
            dec.res0.out_byte = in_byte;
            add_close         = record_last;
         end else if (!esc.known) begin
            dec.res0.out_kind   = KIND_ERROR;
            dec.res0.record_end = 1'b1;
            dec.skip_next       = !record_last;
         end else begin
            dec.res0.out_kind = KIND_DATA;
            dec.res0.out_byte = esc.value;
            add_close         = record_last;
         end
      end else if (in_byte == BACKSLASH) begin
         if (record_last) begin
            dec.count           = 2'd1;
            dec.res0.out_kind   = KIND_ERROR;
            dec.res0.record_end = 1'b1;
         end else begin
            dec.escape_next = 1'b1;
         end
      end else if (in_byte == delim) begin
         dec.count         = 2'd1;
         dec.res0.out_kind = KIND_END;
         add_close         = record_last;
      end else begin
         dec.count         = 2'd1;
         dec.res0.out_kind = KIND_DATA;
         dec.res0.out_byte = in_byte;
         add_close         = record_last;
      end

      // closing field end after a data byte or a delimiter on the last byte
      if (add_close) begin
         dec.count           = 2'd2;
         dec.res1.out_kind   = KIND_END;
         dec.res1.record_end = 1'b1;
         dec.res1.run_last   = 1'b1;
      end
      dec.res0.run_last = (dec.count == 2'd1);
   end

endmodule

[rtl/core/efs_queue.sv]
// efs_queue: small result queue, takes up to two results a cycle, gives one
// depends on efs_pkg

module efs_queue
   import efs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] push_count,
   input  res_type    push_res0,
   input  res_type    push_res1,
   output logic       room_for_two,
   output logic       pop_valid,
   input  logic       pop_ready,
   output res_type    pop_res
);

   res_type             entry_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff,  count_in;
   logic [QPTR_W-1:0]   wr_ptr_next;
   logic                pop;

   assign pop          = pop_valid && pop_ready;
   assign pop_valid    = (count_ff != '0);
   assign pop_res      = entry_ff[rd_ptr_ff];
   assign room_for_two = (count_ff <= QCNT_W'(QDEPTH - 2));
   assign wr_ptr_next  = wr_ptr_ff + QPTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push_count);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      count_in  = count_ff + QCNT_W'(push_count) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_res0;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push_res1;
      end
   end

endmodule

[rtl/core/escaped_field_splitter.sv]
// escaped_field_splitter: splits records into fields, decoding backslash escapes
// depends on efs_pkg, efs_req_if, efs_rsp_if, efs_decode, efs_queue
//
//   channel  | dir | payload                                    | handshake
//   ---------+-----+--------------------------------------------+-------------------
//   req_chan | in  | in_byte, byte_valid, record_last           | valid/ready
//   rsp_chan | out | out_kind, out_byte, record_end, run_last   | valid/ready
//   csr      | in  | csr_wr_data (field delimiter)              | csr_wr_en, no wait
//
// a request beat is decoded in the cycle it is accepted; its zero, one or two
// results are registered into a four-entry result queue and leave one per cycle
// while the response side is ready. one beat a cycle is taken while the queue has
// room for two results; beats that give two results (delimiter or byte on a
// record's last beat) are held back by the single response port. reset clears
// the escape state, the queue and sets the delimiter to a comma; a stalled
// response side fills the queue and drops ready.

module escaped_field_splitter
   import efs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   efs_req_if.sink    req_chan,
   efs_rsp_if.source  rsp_chan,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   // decode state: escape and skip updated on every accepted beat, delimiter on a csr write
   logic       escape_pending_ff, escape_pending_in;
   logic       skip_ff,           skip_in;
   logic [7:0] delim_ff,          delim_in;

   dec_type    dec;
   logic       req_beat;
   logic       room_for_two;
   logic [1:0] push_count;
   res_type    head_res;

   assign req_chan.ready = room_for_two;
   assign req_beat       = req_chan.valid && req_chan.ready;

   efs_decode u_decode (
      .in_byte            (req_chan.in_byte),
      .byte_valid         (req_chan.byte_valid),
      .record_last        (req_chan.record_last),
      .delim              (delim_ff),
      .escape_pending     (escape_pending_ff),
      .skip_to_record_end (skip_ff),
      .dec                (dec)
   );

   // nothing is pushed unless the beat is really taken
   assign push_count = req_beat ? dec.count : 2'd0;

   always_comb begin
      escape_pending_in = req_beat ? dec.escape_next : escape_pending_ff;
      skip_in           = req_beat ? dec.skip_next   : skip_ff;
      delim_in          = csr_wr_en ? csr_wr_data    : delim_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_pending_ff <= 1'b0;
         skip_ff           <= 1'b0;
         delim_ff          <= DELIM_DEFAULT;
      end else begin
         escape_pending_ff <= escape_pending_in;
         skip_ff           <= skip_in;
         delim_ff          <= delim_in;
      end
   end

   efs_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push_count   (push_count),
      .push_res0    (dec.res0),
      .push_res1    (dec.res1),
      .room_for_two (room_for_two),
      .pop_valid    (rsp_chan.valid),
      .pop_ready    (rsp_chan.ready),
      .pop_res      (head_res)
   );

   // head of the queue drives the response payload
   assign rsp_chan.out_kind   = head_res.out_kind;
   assign rsp_chan.out_byte   = head_res.out_byte;
   assign rsp_chan.record_end = head_res.record_end;
   assign rsp_chan.run_last   = head_res.run_last;

endmodule

[tb/efs_split_checker.sv]
// efs_split_checker: watches both channels of the field splitter, predicts every result
// depends on efs_pkg, efs_req_if and efs_rsp_if

module efs_split_checker
   import efs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   efs_req_if         req,
   efs_rsp_if         rsp,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   output int         fail_count,
   output int         results_owed
);

   logic [7:0] delimiter;
   logic       in_escape;
   logic       skipping;
   res_type    field_results_due[$];
   res_type    beat_out[2];
   int         beat_n;
   int         errors = 0;
   int         seen = 0;

   // bit 8 set when the byte names a known escape
   function automatic logic [8:0] escape_lookup(input logic [7:0] c);
      case (c)
         8'h27, 8'h22, 8'h3F, BACKSLASH: return {1'b1, c};
         8'h61:   return {1'b1, 8'h07};
         8'h62:   return {1'b1, 8'h08};
         8'h66:   return {1'b1, 8'h0C};
         8'h6E:   return {1'b1, 8'h0A};
         8'h72:   return {1'b1, 8'h0D};
         8'h74:   return {1'b1, 8'h09};
         8'h76:   return {1'b1, 8'h0B};
         default: return 9'h000;
      endcase
   endfunction

   task automatic add_result(input logic [1:0] kind, input logic [7:0] value,
                             input logic rend);
      beat_out[beat_n].out_kind   = kind;
      beat_out[beat_n].out_byte   = value;
      beat_out[beat_n].record_end = rend;
      beat_out[beat_n].run_last   = 1'b0;
      beat_n++;
   endtask

   task automatic split_beat(input logic [7:0] b, input logic has_byte, input logic closes);
      logic [8:0] esc;
      beat_n = 0;
      if (skipping) begin
         if (closes) begin
            skipping  = 1'b0;
            in_escape = 1'b0;
         end
      end else if (!has_byte) begin
         if (closes) begin
            add_result(in_escape ? KIND_ERROR : KIND_END, 8'h00, 1'b1);
            in_escape = 1'b0;
         end
      end else if (in_escape) begin
         in_escape = 1'b0;
         esc = escape_lookup(b);
         // escaped delimiter is tested before the c escapes
         if (b == delimiter) begin
            add_result(KIND_DATA, b, 1'b0);
            if (closes) add_result(KIND_END, 8'h00, 1'b1);
         end else if (!esc[8]) begin
            add_result(KIND_ERROR, 8'h00, 1'b1);
            if (!closes) skipping = 1'b1;
         end else begin
            add_result(KIND_DATA, esc[7:0], 1'b0);
            if (closes) add_result(KIND_END, 8'h00, 1'b1);
         end
      end else if (b == BACKSLASH) begin
         if (closes) add_result(KIND_ERROR, 8'h00, 1'b1);
         else in_escape = 1'b1;
      end else begin
         if (b == delimiter) add_result(KIND_END, 8'h00, 1'b0);
         else add_result(KIND_DATA, b, 1'b0);
         if (closes) add_result(KIND_END, 8'h00, 1'b1);
      end
      for (int i = 0; i < beat_n; i++) begin
         if (i == beat_n - 1) beat_out[i].run_last = 1'b1;
         field_results_due = {field_results_due, beat_out[i]};
      end
   endtask

   task automatic check_result(input res_type got);
      res_type want;
      seen++;
      if (field_results_due.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("efs check: result %0d unexpected: kind %0d byte %02h rend %b last %b",
                     seen, got.out_kind, got.out_byte, got.record_end, got.run_last);
      end else begin
         want = field_results_due.pop_front();
         if (got.out_kind !== want.out_kind || got.out_byte !== want.out_byte ||
             got.record_end !== want.record_end || got.run_last !== want.run_last) begin
            errors++;
            if (errors <= 10)
               $display({"efs check: result %0d: expected kind %0d byte %02h rend %b last %b,",
                         " got kind %0d byte %02h rend %b last %b"}, seen,
                        want.out_kind, want.out_byte, want.record_end, want.run_last,
                        got.out_kind, got.out_byte, got.record_end, got.run_last);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         delimiter = DELIM_DEFAULT;
         in_escape = 1'b0;
         skipping  = 1'b0;
         field_results_due.delete();
      end else begin
         if (csr_wr_en) delimiter = csr_wr_data;
         if (req.valid && req.ready) split_beat(req.in_byte, req.byte_valid, req.record_last);
         if (rsp.valid && rsp.ready)
            check_result(res_type'({rsp.out_kind, rsp.out_byte, rsp.record_end, rsp.run_last}));
      end
      fail_count   <= errors;
      results_owed <= field_results_due.size();
   end

endmodule

[tb/tb_top.sv]
// tb_top: drives records through the escaped field splitter under several delimiters
// depends on efs_pkg, efs_req_if, efs_rsp_if, escaped_field_splitter and efs_split_checker

module tb_top;
   import efs_pkg::*;

   localparam int ITEMS_PER_PHASE = 200;
   localparam int IDLE_LIMIT      = 2000;   // cycles with no beat on either side

   typedef struct packed {
      logic [7:0] value;
      logic       has_byte;
      logic       closes;
   } rec_beat_type;

   logic         clock;
   logic         reset;
   logic         csr_wr_en;
   logic [7:0]   csr_wr_data;
   int           fail_count;
   int           results_owed;
   bit           gaps_on = 1'b1;
   logic [7:0]   cur_delim = DELIM_DEFAULT;
   int           items_sent = 0;
   int           idle_cycles;
   rec_beat_type record_q[$];

   // opening run, default comma delimiter: plain bytes, field ends, escaped comma,
   // byte extremes, comma on the last beat, empty record, idle beat, lone trailing
   // backslash, escape on the last beat, unknown escape and the skipped tail,
   // pending escape closed by an empty beat, doubled backslash at the end
   rec_beat_type opening [25] = '{
      '{8'h78, 1'b1, 1'b0}, '{8'h2C, 1'b1, 1'b0}, '{8'h5C, 1'b1, 1'b0},
      '{8'h2C, 1'b1, 1'b0}, '{8'h5C, 1'b1, 1'b0}, '{8'h6E, 1'b1, 1'b0},
      '{8'h00, 1'b1, 1'b0}, '{8'hFF, 1'b1, 1'b0}, '{8'h2C, 1'b1, 1'b1},
      '{8'h00, 1'b0, 1'b1}, '{8'h5A, 1'b0, 1'b0}, '{8'h71, 1'b1, 1'b1},
      '{8'h5C, 1'b1, 1'b1}, '{8'h5C, 1'b1, 1'b0}, '{8'h74, 1'b1, 1'b1},
      '{8'h5C, 1'b1, 1'b0}, '{8'h7A, 1'b1, 1'b0}, '{8'h61, 1'b1, 1'b0},
      '{8'h2C, 1'b1, 1'b0}, '{8'h00, 1'b0, 1'b0}, '{8'h62, 1'b1, 1'b1},
      '{8'h5C, 1'b1, 1'b0}, '{8'hFF, 1'b0, 1'b1}, '{8'h5C, 1'b1, 1'b0},
      '{8'h5C, 1'b1, 1'b1}
   };

   // delimiters for the later phases: extremes, backslash, an escape letter, a quote,
   // one random value and back to the comma
   logic [7:0] delim_plan [7] = '{8'h00, 8'hFF, BACKSLASH, 8'h6E, 8'h27, 8'h00, DELIM_DEFAULT};

   efs_req_if req_chan ();
   efs_rsp_if rsp_chan ();

   escaped_field_splitter dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   efs_split_checker split_check (
      .clock        (clock),
      .reset        (reset),
      .req          (req_chan),
      .rsp          (rsp_chan),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .fail_count   (fail_count),
      .results_owed (results_owed)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
      return $urandom_range(1, 3);
   endfunction

   // the c escape letters, with the current delimiter as the twelfth choice
   function automatic logic [7:0] escape_char(input int idx);
      case (idx)
         0:       return 8'h27;   // quote
         1:       return 8'h22;   // double quote
         2:       return 8'h3F;   // question mark
         3:       return BACKSLASH;
         4:       return 8'h61;   // a
         5:       return 8'h62;   // b
         6:       return 8'h66;   // f
         7:       return 8'h6E;   // n
         8:       return 8'h72;   // r
         9:       return 8'h74;   // t
         10:      return 8'h76;   // v
         default: return cur_delim;
      endcase
   endfunction

   // one request beat, held until the block takes it; valid stays high into the
   // next beat when no gap is chosen
   task automatic send_beat(input logic [7:0] value, input logic has_byte, input logic closes);
      int gap;
      gap = (gaps_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.in_byte     <= value;
      req_chan.byte_valid  <= has_byte;
      req_chan.record_last <= closes;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (has_byte || closes) items_sent++;
   endtask

   // appends one beat to the record being built
   task automatic queue_beat(input logic [7:0] value, input logic has_byte,
                             input logic closes);
      rec_beat_type nb;
      nb.value    = value;
      nb.has_byte = has_byte;
      nb.closes   = closes;
      record_q    = {record_q, nb};
   endtask

   // a record of random fields, mostly well formed, with some noise mixed in
   task automatic play_record();
      int len;
      int pick;
      record_q.delete();
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 8);
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(0, 19);
         if (pick <= 8) begin
            queue_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0);
         end else if (pick <= 11) begin
            queue_beat(cur_delim, 1'b1, 1'b0);
         end else if (pick <= 15) begin
            // known escape pair, or an escaped delimiter
            queue_beat(BACKSLASH, 1'b1, 1'b0);
            queue_beat(escape_char($urandom_range(0, 11)), 1'b1, 1'b0);
         end else if (pick == 16) begin
            // backslash before any byte, mostly an unknown escape
            queue_beat(BACKSLASH, 1'b1, 1'b0);
            queue_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0);
         end else if (pick == 17) begin
            queue_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         end else if (pick == 18) begin
            queue_beat(BACKSLASH, 1'b1, 1'b0);
         end else begin
            queue_beat(8'($urandom_range(8'h61, 8'h7A)), 1'b1, 1'b0);
         end
      end
      // close on the last byte, or with an empty closing beat
      if (record_q.size() == 0 || $urandom_range(0, 4) == 0)
         queue_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      else
         record_q[$].closes = 1'b1;
      foreach (record_q[i])
         send_beat(record_q[i].value, record_q[i].has_byte, record_q[i].closes);
   endtask

   task automatic random_phase(input int count);
      int target;
      target = items_sent + count;
      while (items_sent < target) begin
         // stretches with and without idling on both sides
         if ($urandom_range(0, 15) == 0) gaps_on = !gaps_on;
         play_record();
      end
   endtask

   // delimiter change once all owed results have left and the block has settled
   task automatic set_delimiter(input logic [7:0] d);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= d;
      cur_delim = d;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // result side: ready held low for random stalls while gaps are on
   initial begin
      int stall;
      stall = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            stall--;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (gaps_on && $urandom_range(0, 3) == 0) stall = pick_gap();
         end
      end
   end

   // watchdog: too long without a beat on either channel ends the run
   initial begin
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_wr_data          = 8'h00;
      req_chan.valid       = 1'b0;
      req_chan.in_byte     = 8'h00;
      req_chan.byte_valid  = 1'b0;
      req_chan.record_last = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (opening[i])
         send_beat(opening[i].value, opening[i].has_byte, opening[i].closes);
      random_phase(ITEMS_PER_PHASE);

      foreach (delim_plan[i]) begin
         set_delimiter(i == 5 ? 8'($urandom_range(0, 255)) : delim_plan[i]);
         random_phase(ITEMS_PER_PHASE);
      end

      // drain: every owed result out, then a short settle
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && results_owed == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
